// File: hdl/sccs_pkg.sv
// Shared constants and types for the spot cone / sphere cull block.
// No dependencies; imported by sccs_mul, spot_cone_sphere_cull and tb_top.
package sccs_pkg;

    localparam int COORD_W_DEF = 32;
    localparam int DIR_W       = 16;
    localparam int DIR_FRAC    = 14;
    localparam int COORD_FRAC  = 16;
    localparam int PL_SHIFT    = 2 * (COORD_FRAC - DIR_FRAC);
    localparam int OFS_W       = 31;
    localparam int TRIG_W      = 17;
    localparam int TRIG2_W     = 2 * TRIG_W;
    localparam int INV_W       = 32;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int MUL_LIMB    = 32;
    localparam int MUL_LAT     = 5;

    localparam logic [TRIG_W-1:0] COS_RST = TRIG_W'(1) << COORD_FRAC;
    localparam logic [INV_W-1:0]  INV_RST = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOUND_OFFSET = 3'd0,
        REG_BOUND_RADIUS = 3'd1,
        REG_SIN          = 3'd2,
        REG_COS          = 3'd3,
        REG_INV_SIN      = 3'd4
    } t_cfg_reg;

endpackage

// File: hdl/spot_cone_sphere_cull.sv
// Spot light cone versus bounding sphere cull: bounding, pulled-back cone and apex tests.
// Throughput one item per cycle; busy stays low.
// The depth is four chained passes through the limb multiplier (pull-back
// scale, axis offsets, squares and axis projection, squared comparison) plus sum stages.
// Synchronous active-low reset clears the pipeline valid bits and loads register defaults.
// The receiver cannot stall; each result shows for one cycle with o_done. Uses sccs_pkg and sccs_mul.
module spot_cone_sphere_cull #(
    parameter int COORD_WIDTH = sccs_pkg::COORD_W_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [sccs_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [sccs_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic signed [COORD_WIDTH-1:0]         i_sphere_x,
    input  logic signed [COORD_WIDTH-1:0]         i_sphere_y,
    input  logic signed [COORD_WIDTH-1:0]         i_sphere_z,
    input  logic [COORD_WIDTH-2:0]                i_sphere_radius,
    input  logic signed [COORD_WIDTH-1:0]         i_light_pos_x,
    input  logic signed [COORD_WIDTH-1:0]         i_light_pos_y,
    input  logic signed [COORD_WIDTH-1:0]         i_light_pos_z,
    input  logic signed [sccs_pkg::DIR_W-1:0]     i_dir_x,
    input  logic signed [sccs_pkg::DIR_W-1:0]     i_dir_y,
    input  logic signed [sccs_pkg::DIR_W-1:0]     i_dir_z,
    output logic                                  o_done,
    output logic                                  o_intersects
);
    import sccs_pkg::*;

    localparam int NAX   = 3;
    localparam int CW    = COORD_WIDTH;
    localparam int DW    = CW + 1;
    localparam int R_W   = CW - 1;
    localparam int RB_W  = ((R_W > OFS_W) ? R_W : OFS_W) + 1;
    localparam int AR_W  = DIR_W + OFS_W + 1;
    localparam int V1_W  = (((DW + DIR_FRAC) > AR_W) ? (DW + DIR_FRAC) : AR_W) + 1;
    localparam int SQ1_W = 2 * V1_W;
    localparam int TR2_W = 2 * RB_W;
    localparam int CA_W  = (SQ1_W > (TR2_W + 2*DIR_FRAC)) ? SQ1_W : (TR2_W + 2*DIR_FRAC);
    localparam int K_W   = R_W + INV_W;
    localparam int DK_W  = DIR_W + K_W + 1;
    localparam int BK_SH = DIR_FRAC + COORD_FRAC;
    localparam int V2_W  = (((DW + BK_SH) > DK_W) ? (DW + BK_SH) : DK_W) + 1;
    localparam int SQ2_W = 2 * V2_W;
    localparam int P2_W  = DIR_W + V2_W;
    localparam int PL2_W = P2_W + 2;
    localparam int RHS2_W = SQ2_W + TRIG2_W;
    localparam int CB_W  = ((2*PL2_W + PL_SHIFT) > RHS2_W) ? (2*PL2_W + PL_SHIFT) : RHS2_W;
    localparam int SQ3_W = 2 * DW;
    localparam int P3_W  = DIR_W + DW;
    localparam int PL3_W = P3_W + 2;
    localparam int RHS3_W = SQ3_W + TRIG2_W;
    localparam int C3_W  = ((2*PL3_W + PL_SHIFT) > RHS3_W) ? (2*PL3_W + PL_SHIFT) : RHS3_W;
    localparam int R2_W  = 2 * R_W;

    localparam int S_DLT   = 1;
    localparam int S_V1    = S_DLT + 1;
    localparam int S_TR2   = S_DLT + MUL_LAT;
    localparam int S_SQ1   = S_V1 + MUL_LAT + 1;
    localparam int S_CA    = S_SQ1 + 1;
    localparam int S_K     = MUL_LAT;
    localparam int S_DK    = S_K + MUL_LAT;
    localparam int S_V2    = S_DK + 1;
    localparam int S_SUM2  = S_V2 + MUL_LAT + 1;
    localparam int S_B2    = S_SUM2 + MUL_LAT;
    localparam int S_CB    = S_B2 + 1;
    localparam int S_P3    = S_DLT + 1;
    localparam int S_PL3   = S_P3 + 1;
    localparam int S_PL3SQ = S_PL3 + MUL_LAT;
    localparam int S_R2    = MUL_LAT;
    localparam int S_SQ3   = S_DLT + MUL_LAT + 1;
    localparam int S_RHS3  = S_SQ3 + MUL_LAT;
    localparam int S_H3    = S_RHS3 + 1;
    localparam int S_OUT   = S_CB + 1;

    logic [OFS_W-1:0]   r_bound_offset;
    logic [OFS_W-1:0]   r_bound_radius;
    logic [TRIG_W-1:0]  r_sin;
    logic [TRIG_W-1:0]  r_cos;
    logic [INV_W-1:0]   r_inv_sin;
    logic [TRIG2_W-1:0] r_sin2;
    logic [TRIG2_W-1:0] r_cos2;

    logic               w_accept;
    logic [S_OUT:1]     r_vld;

    logic signed [CW-1:0]    w_c   [NAX];
    logic signed [CW-1:0]    w_p   [NAX];
    logic signed [DIR_W-1:0] w_din [NAX];

    logic signed [DW-1:0]    n_dlt [NAX];
    logic signed [DW-1:0]    r_dlt [S_DLT:S_DK][NAX];
    logic signed [DIR_W-1:0] r_d   [S_DLT:S_V2][NAX];

    logic signed [AR_W-1:0]  r_ar [NAX];
    logic signed [AR_W-1:0]  n_ar [NAX];
    logic [RB_W-1:0]         r_rb, n_rb;
    logic signed [V1_W-1:0]  r_v1 [NAX];
    logic signed [V1_W-1:0]  n_v1 [NAX];
    logic [SQ1_W-1:0]        w_sq1p [NAX];
    logic [SQ1_W-1:0]        r_sq1, n_sq1;
    logic [TR2_W-1:0]        w_tr2;
    logic [TR2_W-1:0]        r_tr2 [S_TR2+1:S_SQ1];
    logic                    n_cull_a;
    logic                    r_cull_a [S_CA:S_CB];

    logic [K_W-1:0]          w_k;
    logic [DK_W-1:0]         w_dk [NAX];
    logic signed [V2_W-1:0]  r_v2 [NAX];
    logic signed [V2_W-1:0]  n_v2 [NAX];
    logic [SQ2_W-1:0]        w_sq2p [NAX];
    logic [P2_W-1:0]         w_p2 [NAX];
    logic [SQ2_W-1:0]        r_sq2, n_sq2;
    logic signed [PL2_W-1:0] r_pl2, n_pl2;
    logic                    r_pl2_np [S_SUM2+1:S_B2];
    logic [2*PL2_W-1:0]      w_pl2sq;
    logic [RHS2_W-1:0]       w_rhs2;
    logic                    r_cull_b, n_cull_b;

    logic signed [P3_W-1:0]  r_p3 [NAX];
    logic signed [P3_W-1:0]  n_p3 [NAX];
    logic signed [PL3_W-1:0] r_pl3, n_pl3;
    logic                    r_pl3_np [S_PL3+1:S_RHS3];
    logic [2*PL3_W-1:0]      w_pl3sq;
    logic [2*PL3_W-1:0]      r_pl3sq [S_PL3SQ+1:S_RHS3];
    logic [SQ3_W-1:0]        w_sq3p [NAX];
    logic [SQ3_W-1:0]        r_sq3, n_sq3;
    logic [R2_W-1:0]         w_r2;
    logic [R2_W-1:0]         r_r2 [S_R2+1:S_SQ3];
    logic                    r_in_r [S_SQ3+1:S_RHS3];
    logic [RHS3_W-1:0]       w_rhs3;
    logic                    n_hit3;
    logic                    r_hit3 [S_H3:S_CB];

    logic                    r_intersects, n_intersects;

    assign busy        = 1'b0;
    assign o_cfg_ready = !start && !(|r_vld);
    assign w_accept    = start && !busy;

    assign w_c[0]   = i_sphere_x;
    assign w_c[1]   = i_sphere_y;
    assign w_c[2]   = i_sphere_z;
    assign w_p[0]   = i_light_pos_x;
    assign w_p[1]   = i_light_pos_y;
    assign w_p[2]   = i_light_pos_z;
    assign w_din[0] = i_dir_x;
    assign w_din[1] = i_dir_y;
    assign w_din[2] = i_dir_z;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound_offset <= '0;
            r_bound_radius <= '0;
            r_sin          <= '0;
            r_cos          <= COS_RST;
            r_inv_sin      <= INV_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_BOUND_OFFSET: r_bound_offset <= i_cfg_data[OFS_W-1:0];
                REG_BOUND_RADIUS: r_bound_radius <= i_cfg_data[OFS_W-1:0];
                REG_SIN:          r_sin          <= i_cfg_data[TRIG_W-1:0];
                REG_COS:          r_cos          <= i_cfg_data[TRIG_W-1:0];
                REG_INV_SIN:      r_inv_sin      <= i_cfg_data[INV_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_sin2 <= TRIG2_W'(r_sin) * TRIG2_W'(r_sin);
        r_cos2 <= TRIG2_W'(r_cos) * TRIG2_W'(r_cos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[S_OUT-1:1], w_accept};
        end
    end

    // entry stage: offsets, bounding terms
    always_comb begin
        for (int g = 0; g < NAX; g++) begin
            n_dlt[g] = DW'(w_p[g]) - DW'(w_c[g]);
            n_ar[g]  = AR_W'(w_din[g]) * AR_W'($signed({1'b0, r_bound_offset}));
        end
        n_rb = RB_W'(i_sphere_radius) + RB_W'(r_bound_radius);
    end

    always_ff @(posedge i_clk) begin
        r_dlt[S_DLT] <= n_dlt;
        for (int s = S_DLT + 1; s <= S_DK; s++) begin
            r_dlt[s] <= r_dlt[s-1];
        end
        r_d[S_DLT] <= w_din;
        for (int s = S_DLT + 1; s <= S_V2; s++) begin
            r_d[s] <= r_d[s-1];
        end
        r_ar <= n_ar;
        r_rb <= n_rb;
    end

    // bounding sphere test
    always_comb begin
        for (int g = 0; g < NAX; g++) begin
            n_v1[g] = (V1_W'(r_dlt[S_DLT][g]) <<< DIR_FRAC) + V1_W'(r_ar[g]);
        end
        n_sq1    = w_sq1p[0] + w_sq1p[1] + w_sq1p[2];
        n_cull_a = (CA_W'(r_tr2[S_SQ1]) << (2 * DIR_FRAC)) < CA_W'(r_sq1);
    end

    sccs_mul #(.A_W(RB_W), .B_W(RB_W), .SIGNED(1'b0)) u_tr2 (
        .i_clk (i_clk),
        .i_a   (r_rb),
        .i_b   (r_rb),
        .o_p   (w_tr2)
    );

    always_ff @(posedge i_clk) begin
        r_v1  <= n_v1;
        r_sq1 <= n_sq1;
        r_tr2[S_TR2+1] <= w_tr2;
        for (int s = S_TR2 + 2; s <= S_SQ1; s++) begin
            r_tr2[s] <= r_tr2[s-1];
        end
        r_cull_a[S_CA] <= n_cull_a;
        for (int s = S_CA + 1; s <= S_CB; s++) begin
            r_cull_a[s] <= r_cull_a[s-1];
        end
    end

    // pulled-back cone test
    sccs_mul #(.A_W(R_W), .B_W(INV_W), .SIGNED(1'b0)) u_k (
        .i_clk (i_clk),
        .i_a   (i_sphere_radius),
        .i_b   (r_inv_sin),
        .o_p   (w_k)
    );

    for (genvar g = 0; g < NAX; g++) begin : g_axis
        sccs_mul #(.A_W(V1_W), .B_W(V1_W), .SIGNED(1'b1)) u_sq1 (
            .i_clk (i_clk),
            .i_a   (r_v1[g]),
            .i_b   (r_v1[g]),
            .o_p   (w_sq1p[g])
        );

        sccs_mul #(.A_W(DIR_W), .B_W(K_W + 1), .SIGNED(1'b1)) u_dk (
            .i_clk (i_clk),
            .i_a   (r_d[S_K][g]),
            .i_b   ({1'b0, w_k}),
            .o_p   (w_dk[g])
        );

        sccs_mul #(.A_W(V2_W), .B_W(V2_W), .SIGNED(1'b1)) u_sq2 (
            .i_clk (i_clk),
            .i_a   (r_v2[g]),
            .i_b   (r_v2[g]),
            .o_p   (w_sq2p[g])
        );

        sccs_mul #(.A_W(DIR_W), .B_W(V2_W), .SIGNED(1'b1)) u_p2 (
            .i_clk (i_clk),
            .i_a   (r_d[S_V2][g]),
            .i_b   (r_v2[g]),
            .o_p   (w_p2[g])
        );

        sccs_mul #(.A_W(DW), .B_W(DW), .SIGNED(1'b1)) u_sq3 (
            .i_clk (i_clk),
            .i_a   (r_dlt[S_DLT][g]),
            .i_b   (r_dlt[S_DLT][g]),
            .o_p   (w_sq3p[g])
        );
    end

    always_comb begin
        for (int g = 0; g < NAX; g++) begin
            n_v2[g] = V2_W'($signed(w_dk[g])) - (V2_W'(r_dlt[S_DK][g]) <<< BK_SH);
        end
        n_sq2 = w_sq2p[0] + w_sq2p[1] + w_sq2p[2];
        n_pl2 = PL2_W'($signed(w_p2[0])) + PL2_W'($signed(w_p2[1]))
              + PL2_W'($signed(w_p2[2]));
        n_cull_b = r_pl2_np[S_B2]
                || ((CB_W'(w_pl2sq) << PL_SHIFT) < CB_W'(w_rhs2));
    end

    sccs_mul #(.A_W(PL2_W), .B_W(PL2_W), .SIGNED(1'b1)) u_pl2sq (
        .i_clk (i_clk),
        .i_a   (r_pl2),
        .i_b   (r_pl2),
        .o_p   (w_pl2sq)
    );

    sccs_mul #(.A_W(SQ2_W), .B_W(TRIG2_W), .SIGNED(1'b0)) u_rhs2 (
        .i_clk (i_clk),
        .i_a   (r_sq2),
        .i_b   (r_cos2),
        .o_p   (w_rhs2)
    );

    always_ff @(posedge i_clk) begin
        r_v2  <= n_v2;
        r_sq2 <= n_sq2;
        r_pl2 <= n_pl2;
        r_pl2_np[S_SUM2+1] <= r_pl2[PL2_W-1] || (r_pl2 == '0);
        for (int s = S_SUM2 + 2; s <= S_B2; s++) begin
            r_pl2_np[s] <= r_pl2_np[s-1];
        end
        r_cull_b <= n_cull_b;
    end

    // apex test
    always_comb begin
        for (int g = 0; g < NAX; g++) begin
            n_p3[g] = P3_W'(r_d[S_DLT][g]) * P3_W'(r_dlt[S_DLT][g]);
        end
        n_pl3  = PL3_W'(r_p3[0]) + PL3_W'(r_p3[1]) + PL3_W'(r_p3[2]);
        n_sq3  = w_sq3p[0] + w_sq3p[1] + w_sq3p[2];
        n_hit3 = r_pl3_np[S_RHS3]
              || ((C3_W'(r_pl3sq[S_RHS3]) << PL_SHIFT) < C3_W'(w_rhs3))
              || r_in_r[S_RHS3];
    end

    sccs_mul #(.A_W(R_W), .B_W(R_W), .SIGNED(1'b0)) u_r2 (
        .i_clk (i_clk),
        .i_a   (i_sphere_radius),
        .i_b   (i_sphere_radius),
        .o_p   (w_r2)
    );

    sccs_mul #(.A_W(PL3_W), .B_W(PL3_W), .SIGNED(1'b1)) u_pl3sq (
        .i_clk (i_clk),
        .i_a   (r_pl3),
        .i_b   (r_pl3),
        .o_p   (w_pl3sq)
    );

    sccs_mul #(.A_W(SQ3_W), .B_W(TRIG2_W), .SIGNED(1'b0)) u_rhs3 (
        .i_clk (i_clk),
        .i_a   (r_sq3),
        .i_b   (r_sin2),
        .o_p   (w_rhs3)
    );

    always_ff @(posedge i_clk) begin
        r_p3  <= n_p3;
        r_pl3 <= n_pl3;
        r_sq3 <= n_sq3;
        r_pl3_np[S_PL3+1] <= r_pl3[PL3_W-1] || (r_pl3 == '0);
        for (int s = S_PL3 + 2; s <= S_RHS3; s++) begin
            r_pl3_np[s] <= r_pl3_np[s-1];
        end
        r_pl3sq[S_PL3SQ+1] <= w_pl3sq;
        for (int s = S_PL3SQ + 2; s <= S_RHS3; s++) begin
            r_pl3sq[s] <= r_pl3sq[s-1];
        end
        r_r2[S_R2+1] <= w_r2;
        for (int s = S_R2 + 2; s <= S_SQ3; s++) begin
            r_r2[s] <= r_r2[s-1];
        end
        r_in_r[S_SQ3+1] <= SQ3_W'(r_r2[S_SQ3]) >= r_sq3;
        for (int s = S_SQ3 + 2; s <= S_RHS3; s++) begin
            r_in_r[s] <= r_in_r[s-1];
        end
        r_hit3[S_H3] <= n_hit3;
        for (int s = S_H3 + 1; s <= S_CB; s++) begin
            r_hit3[s] <= r_hit3[s-1];
        end
    end

    // combine the three tests
    assign n_intersects = r_hit3[S_CB] && !r_cull_a[S_CB] && !r_cull_b;

    always_ff @(posedge i_clk) begin
        r_intersects <= n_intersects;
    end

    assign o_done       = r_vld[S_OUT];
    assign o_intersects = r_intersects;

endmodule

// File: hdl/sccs_mul.sv
// Pipelined wide multiplier built from 32x32 limb products.
// Stages: magnitude, partial products, row sums, final sum, sign. Depends on sccs_pkg.
module sccs_mul #(
    parameter int A_W    = 32,
    parameter int B_W    = 32,
    parameter bit SIGNED = 1'b0
) (
    input  logic               i_clk,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic [A_W+B_W-1:0] o_p
);
    import sccs_pkg::*;

    localparam int NA    = (A_W + MUL_LIMB - 1) / MUL_LIMB;
    localparam int NB    = (B_W + MUL_LIMB - 1) / MUL_LIMB;
    localparam int AP_W  = NA * MUL_LIMB;
    localparam int BP_W  = NB * MUL_LIMB;
    localparam int PP_W  = 2 * MUL_LIMB;
    localparam int ROW_W = AP_W + MUL_LIMB;
    localparam int SUM_W = AP_W + BP_W;
    localparam int P_W   = A_W + B_W;

    logic [A_W-1:0]   n_am;
    logic [B_W-1:0]   n_bm;
    logic [AP_W-1:0]  r_a, n_a;
    logic [BP_W-1:0]  r_b, n_b;
    logic             n_neg;
    logic [3:0]       r_neg;
    logic [PP_W-1:0]  r_pp [NA*NB];
    logic [PP_W-1:0]  n_pp [NA*NB];
    logic [ROW_W-1:0] r_row [NB];
    logic [ROW_W-1:0] n_row [NB];
    logic [SUM_W-1:0] n_sum;
    logic [P_W-1:0]   r_sum;
    logic [P_W-1:0]   r_p, n_p;

    always_comb begin
        n_neg = SIGNED && (i_a[A_W-1] ^ i_b[B_W-1]);
        n_am  = (SIGNED && i_a[A_W-1]) ? (~i_a + A_W'(1)) : i_a;
        n_bm  = (SIGNED && i_b[B_W-1]) ? (~i_b + B_W'(1)) : i_b;
        n_a   = AP_W'(n_am);
        n_b   = BP_W'(n_bm);
    end

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                n_pp[i*NB+j] = PP_W'(r_a[i*MUL_LIMB +: MUL_LIMB])
                             * PP_W'(r_b[j*MUL_LIMB +: MUL_LIMB]);
            end
        end
    end

    always_comb begin
        for (int j = 0; j < NB; j++) begin
            n_row[j] = '0;
            for (int i = 0; i < NA; i++) begin
                n_row[j] = n_row[j] + (ROW_W'(r_pp[i*NB+j]) << (i * MUL_LIMB));
            end
        end
    end

    always_comb begin
        n_sum = '0;
        for (int j = 0; j < NB; j++) begin
            n_sum = n_sum + (SUM_W'(r_row[j]) << (j * MUL_LIMB));
        end
    end

    assign n_p = r_neg[3] ? (~r_sum + P_W'(1)) : r_sum;

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_neg <= {r_neg[2:0], n_neg};
        r_pp  <= n_pp;
        r_row <= n_row;
        r_sum <= n_sum[P_W-1:0];
        r_p   <= n_p;
    end

    assign o_p = r_p;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for spot_cone_sphere_cull: a scoreboard class predicts the
// cull verdict of every accepted beat exactly, in wide integers, and checks o_intersects.
// Depends on sccs_pkg and spot_cone_sphere_cull from the hdl folder.
module tb_top;
    import sccs_pkg::*;

    localparam int CW         = COORD_W_DEF;
    localparam int CLK_PERIOD = 10;
    localparam int RST_CYCLES = 12;
    localparam int CULL_LAT   = 24;
    localparam int PHASE_LEN  = 215;
    localparam int N_CONES    = 7;
    localparam int UNIT       = 1 << COORD_FRAC;
    localparam int DIR_ONE    = 1 << DIR_FRAC;
    localparam int CMAX       = 32'sh7FFF_FFFF;
    localparam int CMIN       = 32'sh8000_0000;
    localparam logic [CW-2:0]        RMAX         = '1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam longint TIMEOUT_NS = 5_000_000;

    typedef logic signed [255:0] t_acc;
    localparam t_acc SCALE_DIR = t_acc'(1) << DIR_FRAC;
    localparam t_acc SCALE_PB  = t_acc'(1) << (COORD_FRAC + DIR_FRAC);
    localparam t_acc SCALE_PL  = t_acc'(1) << PL_SHIFT;

    typedef struct {
        logic signed [CW-1:0]    sx, sy, sz;
        logic        [CW-2:0]    rad;
        logic signed [CW-1:0]    lx, ly, lz;
        logic signed [DIR_W-1:0] dx, dy, dz;
    } t_cull_item;

    typedef struct {
        logic [CFG_DATA_W-1:0] ofs, rad, sn, cs, inv;
    } t_cone_cfg;

    class cull_scoreboard;
        logic [OFS_W-1:0]  bnd_ofs, bnd_rad;
        logic [TRIG_W-1:0] sin_h, cos_h;
        logic [INV_W-1:0]  inv_sin;
        bit                verdict_q[$];
        int unsigned       err_cnt;

        function new();
            bnd_ofs = '0;
            bnd_rad = '0;
            sin_h   = '0;
            cos_h   = COS_RST;
            inv_sin = INV_RST;
            err_cnt = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_BOUND_OFFSET: bnd_ofs = data[OFS_W-1:0];
                REG_BOUND_RADIUS: bnd_rad = data[OFS_W-1:0];
                REG_SIN:          sin_h   = data[TRIG_W-1:0];
                REG_COS:          cos_h   = data[TRIG_W-1:0];
                REG_INV_SIN:      inv_sin = data[INV_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_item(t_cull_item item);
            t_acc cx, cy, cz, px, py, pz, dx, dy, dz, rad;
            t_acc bo, br, sn, cs, inv, pull, tr;
            t_acc vx, vy, vz, mag2, proj;
            bit   hit;
            cx = item.sx;  cy = item.sy;  cz = item.sz;
            px = item.lx;  py = item.ly;  pz = item.lz;
            dx = item.dx;  dy = item.dy;  dz = item.dz;
            rad = item.rad;
            bo = bnd_ofs;  br = bnd_rad;
            sn = sin_h;    cs = cos_h;    inv = inv_sin;
            // bounding sphere of the cone
            vx = (px - cx) * SCALE_DIR + dx * bo;
            vy = (py - cy) * SCALE_DIR + dy * bo;
            vz = (pz - cz) * SCALE_DIR + dz * bo;
            mag2 = vx * vx + vy * vy + vz * vz;
            tr = (rad + br) * SCALE_DIR;
            if (tr * tr < mag2) begin
                hit = 1'b0;
            end else begin
                // cone with apex pulled back by r/sin
                pull = rad * inv;
                vx = (cx - px) * SCALE_PB + dx * pull;
                vy = (cy - py) * SCALE_PB + dy * pull;
                vz = (cz - pz) * SCALE_PB + dz * pull;
                mag2 = vx * vx + vy * vy + vz * vz;
                proj = dx * vx + dy * vy + dz * vz;
                if (proj <= 0 || proj * proj * SCALE_PL < mag2 * cs * cs) begin
                    hit = 1'b0;
                end else begin
                    // apex region
                    vx = cx - px;
                    vy = cy - py;
                    vz = cz - pz;
                    mag2 = vx * vx + vy * vy + vz * vz;
                    proj = -(dx * vx + dy * vy + dz * vz);
                    hit = (proj <= 0) || (proj * proj * SCALE_PL < mag2 * sn * sn)
                        || (rad * rad >= mag2);
                end
            end
            verdict_q.push_back(hit);
        endfunction

        function void check_result(logic got);
            bit want;
            if (verdict_q.size() == 0) begin
                $error("intersects: expected none, actual %0b", got);
                err_cnt++;
            end else begin
                want = verdict_q.pop_front();
                if (got !== want) begin
                    $error("intersects: expected %0b, actual %0b", want, got);
                    err_cnt++;
                end
            end
        endfunction

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic                  i_clk     = 1'b0;
    logic                  i_rst_n   = 1'b0;
    logic                  start     = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    t_cull_item            drv       = '{default: '0};
    logic                  busy, o_cfg_ready, o_done, o_intersects;

    cull_scoreboard sb = new();

    spot_cone_sphere_cull #(.COORD_WIDTH(CW)) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_sphere_x     (drv.sx),
        .i_sphere_y     (drv.sy),
        .i_sphere_z     (drv.sz),
        .i_sphere_radius(drv.rad),
        .i_light_pos_x  (drv.lx),
        .i_light_pos_y  (drv.ly),
        .i_light_pos_z  (drv.lz),
        .i_dir_x        (drv.dx),
        .i_dir_y        (drv.dy),
        .i_dir_z        (drv.dz),
        .o_done         (o_done),
        .o_intersects   (o_intersects)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) sb.note_item(drv);
            if (o_done) sb.check_result(o_intersects);
            if (cfg_valid && o_cfg_ready) sb.set_reg(cfg_idx, cfg_data);
        end
    end

    function automatic t_cull_item mk_item(int sx, int sy, int sz, logic [CW-2:0] rad,
                                           int lx, int ly, int lz, int dx, int dy, int dz);
        t_cull_item item;
        item.sx = CW'(sx);  item.sy = CW'(sy);  item.sz = CW'(sz);  item.rad = rad;
        item.lx = CW'(lx);  item.ly = CW'(ly);  item.lz = CW'(lz);
        item.dx = DIR_W'(dx);  item.dy = DIR_W'(dy);  item.dz = DIR_W'(dz);
        return item;
    endfunction

    function automatic t_cull_item rand_item();
        t_cull_item item;
        int  kind, amp, ix, iy, iz, sel;
        real ux, uy, uz, nrm, t, ox, oy, oz;
        kind = $urandom_range(99);
        item.lx = $urandom;  item.ly = $urandom;  item.lz = $urandom;
        item.sx = $urandom;  item.sy = $urandom;  item.sz = $urandom;
        item.rad = (CW-1)'($urandom);
        if ($urandom_range(9) == 0) begin
            ix = $urandom_range(2 * DIR_ONE) - DIR_ONE;
            iy = $urandom_range(2 * DIR_ONE) - DIR_ONE;
            iz = $urandom_range(2 * DIR_ONE) - DIR_ONE;
        end else begin
            ux = $urandom_range(2000) / 1000.0 - 1.0;
            uy = $urandom_range(2000) / 1000.0 - 1.0;
            uz = $urandom_range(2000) / 1000.0 - 1.0;
            nrm = $sqrt(ux * ux + uy * uy + uz * uz);
            if (nrm < 0.05) begin
                ux = 0.0;  uy = 0.0;  uz = 1.0;  nrm = 1.0;
            end
            ix = $rtoi(ux / nrm * DIR_ONE);
            iy = $rtoi(uy / nrm * DIR_ONE);
            iz = $rtoi(uz / nrm * DIR_ONE);
        end
        item.dx = DIR_W'(ix);  item.dy = DIR_W'(iy);  item.dz = DIR_W'(iz);
        if (kind < 85) begin
            sel = $urandom_range(9);
            if (kind >= 70) begin
                t = $urandom_range(100) / 10.0 - 8.0;
                amp = $urandom_range(3);
                item.rad = (CW-1)'($urandom_range(16 * UNIT));
            end else begin
                t = $urandom_range(1120) / 10.0 - 16.0;
                amp = $urandom_range(40);
                if (sel < 7) item.rad = (CW-1)'($urandom_range(8 * UNIT));
                else if (sel < 9) item.rad = (CW-1)'($urandom_range(64 * UNIT));
            end
            ox = ix * t / DIR_ONE + ($urandom_range(2000) / 1000.0 - 1.0) * amp;
            oy = iy * t / DIR_ONE + ($urandom_range(2000) / 1000.0 - 1.0) * amp;
            oz = iz * t / DIR_ONE + ($urandom_range(2000) / 1000.0 - 1.0) * amp;
            item.sx = item.lx + $rtoi(ox * UNIT);
            item.sy = item.ly + $rtoi(oy * UNIT);
            item.sz = item.lz + $rtoi(oz * UNIT);
        end
        return item;
    endfunction

    task automatic send_item(t_cull_item item, int idle_pct);
        int gap;
        drv   <= item;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        if ($urandom_range(99) < idle_pct) begin
            gap = $urandom_range(12, 1);
            start <= 1'b0;
            repeat (gap) begin
                drv <= rand_item();
                @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (CULL_LAT + 4) @(posedge i_clk);
    endtask

    task automatic program_regs(t_cone_cfg cfg);
        logic [CFG_IDX_W-1:0]  idx [6];
        logic [CFG_DATA_W-1:0] val [6];
        idx = '{REG_BOUND_OFFSET, REG_BOUND_RADIUS, REG_SIN, REG_COS, REG_INV_SIN,
                REG_SPARE_LO + CFG_IDX_W'($urandom_range(2))};
        val = '{cfg.ofs, cfg.rad, cfg.sn, cfg.cs, cfg.inv, $urandom};
        for (int k = 0; k < 6; k++) begin
            cfg_valid <= 1'b1;
            cfg_idx   <= idx[k];
            cfg_data  <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("status: fail");
        $finish;
    end

    initial begin
        t_cone_cfg cones [N_CONES];
        int        idle_pct [4];
        idle_pct  = '{0, 77, 0, 18};
        cones[0] = '{32'd2421540, 32'd2421540, 32'd32768, 32'd56756, 32'd131072};
        cones[1] = '{32'd2129500, 32'd2129500, 32'd11380, 32'd64540, 32'd377404};
        cones[2] = '{32'd2965820, 32'd2965820, 32'd46341, 32'd46341, 32'd92682};
        cones[3] = '{32'd0, 32'd4194304, 32'd65536, 32'd0, 32'd65536};
        cones[4] = '{32'd2097152, 32'd2097152, 32'd0, 32'd65536, 32'hFFFF_FFFF};
        cones[5] = '{default: 32'hFFFF_FFFF};
        cones[6] = '{$urandom_range(128 * UNIT), $urandom_range(128 * UNIT),
                     $urandom, $urandom, $urandom};

        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values: zero sine, saturated reciprocal, empty bound
        send_item(mk_item(0, 0, 0, '0, 0, 0, 0, 0, 0, 0), 0);
        send_item(mk_item(5 * UNIT, -3 * UNIT, 2 * UNIT, UNIT,
                          5 * UNIT, -3 * UNIT, 2 * UNIT, 0, 0, DIR_ONE), 0);
        send_item(mk_item(UNIT, 0, 0, 2 * UNIT, 0, 0, 0, DIR_ONE, 0, 0), 0);
        send_item(mk_item(0, 0, 3 * UNIT, 4 * UNIT, 0, 0, 0, 0, 0, DIR_ONE), 0);
        wait_drained();

        program_regs(cones[0]);
        send_item(mk_item(0, 0, 30 * UNIT, UNIT, 0, 0, 0, 0, 0, DIR_ONE), 0);
        send_item(mk_item(40 * UNIT, 0, 10 * UNIT, UNIT, 0, 0, 0, 0, 0, DIR_ONE), 0);
        send_item(mk_item(0, 0, -5 * UNIT, UNIT, 0, 0, 0, 0, 0, DIR_ONE), 0);
        send_item(mk_item(0, 0, -2 * UNIT, 4 * UNIT, 0, 0, 0, 0, 0, DIR_ONE), 0);
        send_item(mk_item(0, 0, 200 * UNIT, UNIT, 0, 0, 0, 0, 0, DIR_ONE), 0);
        send_item(mk_item(CMAX, CMAX, CMAX, RMAX, CMIN, CMIN, CMIN,
                          DIR_ONE, DIR_ONE, DIR_ONE), 0);
        send_item(mk_item(CMIN, CMIN, CMIN, '0, CMAX, CMAX, CMAX,
                          -DIR_ONE, -DIR_ONE, -DIR_ONE), 0);
        send_item(mk_item(UNIT, UNIT, 0, UNIT, 0, 0, 0, 0, 0, 0), 0);
        send_item(mk_item(-20 * UNIT, 0, 0, UNIT, 0, 0, 0, -DIR_ONE, 0, 0), 0);
        send_item(mk_item(0, 20 * UNIT, 3 * UNIT, '0, 0, 0, 0, 0, DIR_ONE, 0), 0);
        send_item(mk_item(3 * UNIT, -UNIT, 0, RMAX, 0, 0, 0, 0, 0, DIR_ONE), 0);
        send_item(mk_item(20 * UNIT, 0, 0, UNIT, 0, 0, 0, DIR_ONE / 2, 0, 0), 0);
        send_item(mk_item(CMAX, 0, CMIN, RMAX, CMAX, 0, CMIN, 0, -DIR_ONE, 0), 0);

        for (int p = 0; p < N_CONES; p++) begin
            wait_drained();
            program_regs(cones[p]);
            for (int i = 0; i < PHASE_LEN; i++) begin
                // hold until the pipe is empty once per phase
                if (i == PHASE_LEN / 2) wait_drained();
                send_item(rand_item(), idle_pct[p % 4]);
            end
        end

        wait_drained();
        if (sb.err_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// File: files.f
hdl/sccs_pkg.sv
hdl/sccs_mul.sv
hdl/spot_cone_sphere_cull.sv
verif/tb_top.sv
